[rtl/lsbd_pkg.sv]
// Shared types and constants for the LiDAR scan binning block.
// Used by lsbd_alu, lsbd_mem and lidar_scan_bin_double_buffer; no dependencies.
`timescale 1ns / 1ps

package lsbd_pkg;

    // Bin geometry: two banks of whole-degree bins
    localparam int ANGLE_BINS = 360;
    localparam int BIN_DEPTH  = 2 * ANGLE_BINS;
    localparam int ADDR_W     = $clog2(BIN_DEPTH);
    localparam int BIN_W      = $clog2(ANGLE_BINS + 1);

    // Shared arithmetic unit widths
    localparam int ALU_W = 18;
    localparam int ALU_Y = 2 * ALU_W;

    // Arithmetic constants
    localparam logic [ALU_W-1:0] FULL_TURN_X100 = 18'd36000;
    localparam logic [ALU_W-1:0] ROUND_HALF     = 18'd50;
    localparam logic [ALU_W-1:0] DEG_SCALE      = 18'd100;
    localparam logic [ALU_W-1:0] BINS_CONST     = 18'd360;
    // floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
    localparam logic [ALU_W-1:0] RECIP_100      = 18'd5243;
    localparam int               RECIP_100_SH   = 19;
    // floor(x / 360) = (x * 93207) >> 25, exact for any 16-bit x
    localparam logic [ALU_W-1:0] RECIP_360      = 18'd93207;
    localparam int               RECIP_360_SH   = 25;
    localparam logic signed [ALU_W-1:0] ERR_LO  = -18'sd18000;
    localparam logic signed [ALU_W-1:0] ERR_HI  = 18'sd18000;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MIN_UNIQUE = 2'd0;
    localparam t_cfg_idx CFG_MIN_POINTS = 2'd1;
    localparam t_cfg_idx CFG_MAX_DELTA  = 2'd2;
    localparam t_cfg_idx CFG_NO_DIST    = 2'd3;
    localparam int       CFG_DATA_W     = 16;

    // Command codes
    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    // Input item
    typedef struct packed {
        logic        cmd;
        logic [15:0] point_angle_x100;
        logic [15:0] point_distance;
        logic [7:0]  point_quality;
        logic        scan_done;
        logic [15:0] query_degree;
    } t_in;

    // Result item
    typedef struct packed {
        logic               found;
        logic [15:0]        asked_degree;
        logic [15:0]        matched_angle_x100;
        logic signed [15:0] angle_error_x100;
        logic [15:0]        hit_distance;
        logic [7:0]         hit_quality;
        logic [31:0]        scan_number;
        logic [8:0]         bins_filled;
        logic [31:0]        scans_dropped;
    } t_out;

    // One bin entry of the store
    typedef struct packed {
        logic        valid;
        logic [15:0] distance;
        logic [15:0] angle;
        logic [7:0]  quality;
    } t_entry;

endpackage

[rtl/lidar_scan_bin_double_buffer.sv]
// LiDAR scan binning with a double-buffered bin store. A zero-distance point is
// not binned; a scan-done point commits or drops the write bank, a sweep clears
// the new write bank, and then the point is binned. A query reduces its degree
// modulo 360, searches offset by offset up to the delta and on a hit works out the
// angular error; the single-port bin store and shared arithmetic unit serialize
// these steps. After reset a sweep clears both banks; no item is taken meanwhile.
// Reset is synchronous, active low. Depends on lsbd_pkg, lsbd_alu and lsbd_mem.
`timescale 1ns / 1ps

module lidar_scan_bin_double_buffer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  lsbd_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output lsbd_pkg::t_out                   o_out,
    input  logic                             i_cfg_we,
    input  lsbd_pkg::t_cfg_idx               i_cfg_addr,
    input  logic [lsbd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lsbd_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_FIN,
        P_MOD, P_RND, P_MUL, P_ADR, P_RD, P_WR,
        Q_DIV, Q_MUL, Q_REM, Q_UR, Q_UC, Q_LC,
        Q_E1, Q_E2, Q_E3, Q_OUT
    } t_state;

    localparam logic [ADDR_W-1:0] BANK1_BASE = ADDR_W'(ANGLE_BINS);
    localparam logic [ADDR_W-1:0] BANK_LAST  = ADDR_W'(ANGLE_BINS - 1);
    localparam logic [BIN_W-1:0]  BIN_MAX    = BIN_W'(ANGLE_BINS - 1);
    localparam logic [BIN_W-1:0]  BIN_WRAP   = BIN_W'(ANGLE_BINS);

    t_state              r_state;
    t_in                 r_in;
    logic [8:0]          r_cfg_min_uniq;
    logic [15:0]         r_cfg_min_pts;
    logic [7:0]          r_cfg_delta;
    logic [15:0]         r_cfg_no_dist;
    logic                r_bank;
    logic                r_have;
    logic [31:0]         r_commit;
    logic [31:0]         r_drop;
    logic [BIN_W-1:0]    r_wuniq;
    logic [15:0]         r_wacc;
    logic [BIN_W-1:0]    r_runiq;
    logic [ALU_W-1:0]    r_t;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_clr_end;
    logic                r_clr_pt;
    logic [BIN_W-1:0]    r_req;
    logic [BIN_W-1:0]    r_up;
    logic [BIN_W-1:0]    r_lo;
    logic [7:0]          r_off;
    logic                r_found;
    t_entry              r_hit;
    t_out                r_out;
    logic                r_out_valid;

    t_alu_op             alu_op;
    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic [ALU_Y-1:0]    alu_y;
    logic [ADDR_W-1:0]   rbase;
    logic [ADDR_W-1:0]   wbase;
    logic [ADDR_W-1:0]   new_wbase;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    t_entry              mem_wdata;
    t_entry              mem_rdata;
    logic                commit;
    logic [BIN_W-1:0]    idx_raw;
    logic signed [ALU_W-1:0] err;

    // Bank bases and commit decision
    assign rbase     = r_bank ? BANK1_BASE : '0;
    assign wbase     = r_bank ? '0 : BANK1_BASE;
    assign commit    = (r_wuniq >= r_cfg_min_uniq) && (r_wacc >= r_cfg_min_pts);
    assign new_wbase = commit ? rbase : wbase;
    assign idx_raw   = alu_y[RECIP_100_SH +: BIN_W];
    assign err       = $signed(r_t);

    // Operand selection for the shared unit
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = r_t;
        alu_b  = '0;
        case (r_state)
            P_MOD: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(r_in.point_angle_x100);
                alu_b  = FULL_TURN_X100;
            end
            P_RND: begin
                alu_op = ALU_ADD;
                alu_b  = ROUND_HALF;
            end
            P_MUL: begin
                alu_op = ALU_MUL;
                alu_b  = RECIP_100;
            end
            Q_DIV: begin
                alu_op = ALU_MUL;
                alu_a  = ALU_W'(r_in.query_degree);
                alu_b  = RECIP_360;
            end
            Q_MUL: begin
                alu_op = ALU_MUL;
                alu_b  = BINS_CONST;
            end
            Q_REM: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(r_in.query_degree);
            end
            Q_E1: begin
                alu_op = ALU_MUL;
                alu_a  = ALU_W'(r_req);
                alu_b  = DEG_SCALE;
            end
            Q_E2: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(r_hit.angle);
            end
            Q_E3: begin
                alu_op = (err <= ERR_LO) ? ALU_ADD : ALU_SUB;
                alu_b  = FULL_TURN_X100;
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
        if (r_state == Q_REM) begin
            alu_b = r_t;
        end
        if (r_state == Q_E2) begin
            alu_b = r_t;
        end
    end

    lsbd_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    // Store address and write data
    always_comb begin
        case (r_state)
            Q_UR:    mem_addr = rbase + ADDR_W'(r_up);
            Q_UC:    mem_addr = rbase + ADDR_W'(r_lo);
            default: mem_addr = r_addr;
        endcase
    end

    assign mem_we = (r_state == S_CLR) || (r_state == P_WR);

    always_comb begin
        if (r_state == S_CLR) begin
            mem_wdata = '0;
        end else begin
            mem_wdata.valid    = 1'b1;
            mem_wdata.distance = r_in.point_distance;
            mem_wdata.angle    = r_in.point_angle_x100;
            mem_wdata.quality  = r_in.point_quality;
        end
    end

    lsbd_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Sequencer, counters, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_addr         <= '0;
            r_clr_end      <= ADDR_W'(BIN_DEPTH - 1);
            r_clr_pt       <= 1'b0;
            r_cfg_min_uniq <= 9'd180;
            r_cfg_min_pts  <= 16'd180;
            r_cfg_delta    <= 8'd5;
            r_cfg_no_dist  <= 16'hFFFF;
            r_bank         <= 1'b0;
            r_have         <= 1'b0;
            r_commit       <= '0;
            r_drop         <= '0;
            r_wuniq        <= '0;
            r_wacc         <= '0;
            r_runiq        <= '0;
            r_found        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MIN_UNIQUE: r_cfg_min_uniq <= i_cfg_data[8:0];
                    CFG_MIN_POINTS: r_cfg_min_pts  <= i_cfg_data;
                    CFG_MAX_DELTA:  r_cfg_delta    <= i_cfg_data[7:0];
                    CFG_NO_DIST:    r_cfg_no_dist  <= i_cfg_data;
                    default:        r_cfg_delta    <= r_cfg_delta;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (r_out_valid && i_out_ready && (r_state != Q_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                // Sweep a bank range clear
                S_CLR: begin
                    if (r_addr == r_clr_end) begin
                        r_clr_pt <= 1'b0;
                        if (r_clr_pt && (r_in.point_distance != '0)) begin
                            r_state <= P_MOD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in;
                        r_found <= 1'b0;
                        if (i_in.cmd == CMD_QUERY) begin
                            r_state <= Q_DIV;
                        end else if (i_in.scan_done) begin
                            r_state <= S_FIN;
                        end else if (i_in.point_distance != '0) begin
                            r_state <= P_MOD;
                        end
                    end
                end
                // Commit or drop the write bank, then clear the new write bank
                S_FIN: begin
                    if (commit) begin
                        r_bank   <= ~r_bank;
                        r_have   <= 1'b1;
                        r_commit <= r_commit + 1'b1;
                        r_runiq  <= r_wuniq;
                    end else if (r_wacc != '0) begin
                        r_drop <= r_drop + 1'b1;
                    end
                    r_wuniq   <= '0;
                    r_wacc    <= '0;
                    r_addr    <= new_wbase;
                    r_clr_end <= new_wbase + BANK_LAST;
                    r_clr_pt  <= 1'b1;
                    r_state   <= S_CLR;
                end
                // Point: reduce the angle below a full turn
                P_MOD: begin
                    r_t     <= alu_y[ALU_W-1] ? ALU_W'(r_in.point_angle_x100)
                                              : alu_y[ALU_W-1:0];
                    r_state <= P_RND;
                end
                P_RND: begin
                    r_t     <= alu_y[ALU_W-1:0];
                    r_state <= P_MUL;
                end
                // Divide by 100 through the reciprocal, fold 360 onto bin 0
                P_MUL: begin
                    r_t     <= (idx_raw == BIN_WRAP) ? '0 : ALU_W'(idx_raw);
                    r_state <= P_ADR;
                end
                P_ADR: begin
                    r_addr  <= wbase + ADDR_W'(r_t[BIN_W-1:0]);
                    r_state <= P_RD;
                end
                P_RD: begin
                    r_state <= P_WR;
                end
                P_WR: begin
                    if (!mem_rdata.valid) begin
                        r_wuniq <= r_wuniq + 1'b1;
                    end
                    if (r_wacc != 16'hFFFF) begin
                        r_wacc <= r_wacc + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                // Query: reduce the degree modulo 360
                Q_DIV: begin
                    r_t     <= ALU_W'(alu_y[RECIP_360_SH +: 8]);
                    r_state <= Q_MUL;
                end
                Q_MUL: begin
                    r_t     <= alu_y[ALU_W-1:0];
                    r_state <= Q_REM;
                end
                Q_REM: begin
                    r_req   <= alu_y[BIN_W-1:0];
                    r_up    <= alu_y[BIN_W-1:0];
                    r_lo    <= alu_y[BIN_W-1:0];
                    r_off   <= '0;
                    r_state <= r_have ? Q_UR : Q_OUT;
                end
                Q_UR: begin
                    r_state <= Q_UC;
                end
                // Upper neighbour first, then the lower one if distinct
                Q_UC: begin
                    if (mem_rdata.valid) begin
                        r_hit   <= mem_rdata;
                        r_found <= 1'b1;
                        r_state <= Q_E1;
                    end else if (r_lo != r_up) begin
                        r_state <= Q_LC;
                    end else if (r_off == r_cfg_delta) begin
                        r_state <= Q_OUT;
                    end else begin
                        r_off   <= r_off + 1'b1;
                        r_up    <= (r_up == BIN_MAX) ? '0 : r_up + 1'b1;
                        r_lo    <= (r_lo == '0) ? BIN_MAX : r_lo - 1'b1;
                        r_state <= Q_UR;
                    end
                end
                Q_LC: begin
                    if (mem_rdata.valid) begin
                        r_hit   <= mem_rdata;
                        r_found <= 1'b1;
                        r_state <= Q_E1;
                    end else if (r_off == r_cfg_delta) begin
                        r_state <= Q_OUT;
                    end else begin
                        r_off   <= r_off + 1'b1;
                        r_up    <= (r_up == BIN_MAX) ? '0 : r_up + 1'b1;
                        r_lo    <= (r_lo == '0) ? BIN_MAX : r_lo - 1'b1;
                        r_state <= Q_UR;
                    end
                end
                // Angular error: stored angle minus requested degree x100
                Q_E1: begin
                    r_t     <= alu_y[ALU_W-1:0];
                    r_state <= Q_E2;
                end
                Q_E2: begin
                    r_t     <= alu_y[ALU_W-1:0];
                    r_state <= Q_E3;
                end
                // Wrap into the half-open turn
                Q_E3: begin
                    if ((err <= ERR_LO) || (err > ERR_HI)) begin
                        r_t <= alu_y[ALU_W-1:0];
                    end else begin
                        r_state <= Q_OUT;
                    end
                end
                // Hold until the result register is free
                Q_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.found              <= r_found;
                        r_out.asked_degree       <= r_in.query_degree;
                        r_out.matched_angle_x100 <= r_found ? r_hit.angle : '0;
                        r_out.angle_error_x100   <= r_found ? $signed(r_t[15:0]) : '0;
                        r_out.hit_distance       <= r_found ? r_hit.distance : r_cfg_no_dist;
                        r_out.hit_quality        <= r_found ? r_hit.quality : '0;
                        r_out.scan_number        <= r_commit;
                        r_out.bins_filled        <= r_have ? r_runiq : '0;
                        r_out.scans_dropped      <= r_drop;
                        r_out_valid              <= 1'b1;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_found_has_bins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.found |-> o_out.bins_filled != '0)
        else $error("hit reported from an empty committed scan");

    a_uniq_le_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        16'(r_wuniq) <= r_wacc)
        else $error("unique bins exceed accepted points");

    a_uniq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wuniq <= BIN_W'(ANGLE_BINS))
        else $error("unique bin count beyond bin total");

    a_off_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == Q_UR) |-> r_off <= r_cfg_delta)
        else $error("search offset beyond delta");

    a_runiq_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_runiq != '0) |-> r_have)
        else $error("committed bin count without a committed scan");
`endif

endmodule

[rtl/lsbd_alu.sv]
// Shared arithmetic unit: add, subtract or multiply on 18-bit operands.
// Depends on lsbd_pkg.
`timescale 1ns / 1ps

module lsbd_alu (
    input  lsbd_pkg::t_alu_op                i_op,
    input  logic [lsbd_pkg::ALU_W-1:0]       i_a,
    input  logic [lsbd_pkg::ALU_W-1:0]       i_b,
    output logic [lsbd_pkg::ALU_Y-1:0]       o_y
);
    import lsbd_pkg::*;

    // Add and subtract in two's complement, multiply unsigned
    always_comb begin
        case (i_op)
            ALU_ADD: o_y = {{ALU_W{i_a[ALU_W-1]}}, i_a} + {{ALU_W{i_b[ALU_W-1]}}, i_b};
            ALU_SUB: o_y = {{ALU_W{i_a[ALU_W-1]}}, i_a} - {{ALU_W{i_b[ALU_W-1]}}, i_b};
            ALU_MUL: o_y = {{ALU_W{1'b0}}, i_a} * {{ALU_W{1'b0}}, i_b};
            default: o_y = '0;
        endcase
    end

endmodule

[rtl/lsbd_mem.sv]
// Bin store for both banks: one port, registered read data.
// Depends on lsbd_pkg.
`timescale 1ns / 1ps

module lsbd_mem (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [lsbd_pkg::ADDR_W-1:0]    i_addr,
    input  lsbd_pkg::t_entry               i_wdata,
    output lsbd_pkg::t_entry               o_rdata
);
    import lsbd_pkg::*;

    t_entry r_mem [BIN_DEPTH];

    // Write on enable, otherwise read the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule
